@@ rtl/esh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esh_pkg: shared types and constants for the ELF symbol hash front end
// Field widths, register indexes, bucket count limits and the request and
// response structs that pass between the sequencer and the modulo unit.
// ----------------------------------------------------------------------------
package esh_pkg;

	localparam int NAME_W           = 8;
	localparam int GNU_W            = 32;
	localparam int SYSV_W           = 28;
	localparam int MAX_BUCKETS_LOG2 = 20;
	localparam int COUNT_W          = MAX_BUCKETS_LOG2 + 1;
	localparam int BUCKET_W         = MAX_BUCKETS_LOG2;
	localparam int BLOOM_W          = 20;
	localparam int BLOOM_LOG2_W     = 5;
	localparam int BLOOM_LOG2_MAX   = 20;
	localparam int SHIFT_W          = 5;
	localparam int MASK_W           = 64;
	localparam int MASK_IDX_W       = 6;
	localparam int BLOOM_LSB        = 6;
	localparam int STEP_W           = $clog2(GNU_W);
	localparam int CFG_IDX_W        = 3;

	localparam logic [GNU_W-1:0] GNU_SEED = GNU_W'(5381);

	localparam logic [CFG_IDX_W-1:0] REG_GNU_COUNT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SYSV_COUNT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BLOOM_LOG2  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BLOOM_SHIFT = CFG_IDX_W'(3);

	localparam logic [COUNT_W-1:0] BUCKET_LIMIT = COUNT_W'(1) << MAX_BUCKETS_LOG2;

	typedef struct packed {
		logic               start;
		logic [GNU_W-1:0]   dividend;
		logic [COUNT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic                done;
		logic [BUCKET_W-1:0] rem;
	} mod_rsp_t;

	// zero counts as one, anything above the limit saturates to it
	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] n;
		begin
			n = count;
			if (count == '0) begin
				n = COUNT_W'(1);
			end else if (count > BUCKET_LIMIT) begin
				n = BUCKET_LIMIT;
			end
			return n;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/esh_hash_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esh_hash_core: running GNU and System V hashes
// Folds one name byte per cycle into both hashes and restarts them when the
// name ends. Bytes are folded only on cycles where step is high.
// ----------------------------------------------------------------------------
module esh_hash_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        restart,
	input  wire logic [esh_pkg::NAME_W-1:0]  byte_in,
	output logic      [esh_pkg::GNU_W-1:0]   gnu_run,
	output logic      [esh_pkg::SYSV_W-1:0]  sysv_run
);

	logic [esh_pkg::GNU_W-1:0]  gnu_q;
	logic [esh_pkg::SYSV_W-1:0] sysv_q;
	logic [esh_pkg::GNU_W-1:0]  gnu_next;
	logic [esh_pkg::GNU_W-1:0]  sysv_wide;
	logic [3:0]                 top_nib;
	logic [esh_pkg::SYSV_W-1:0] sysv_next;

	always_comb begin
		// h * 33 + c as shift and add
		gnu_next  = (gnu_q << 5) + gnu_q + esh_pkg::GNU_W'(byte_in);
		sysv_wide = {sysv_q, 4'b0000} + esh_pkg::GNU_W'(byte_in);
		top_nib   = sysv_wide[esh_pkg::GNU_W-1 -: 4];
		// fold the top nibble into bits 7..4, drop it from the top
		sysv_next = sysv_wide[esh_pkg::SYSV_W-1:0]
			^ esh_pkg::SYSV_W'({top_nib, 4'b0000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gnu_q  <= esh_pkg::GNU_SEED;
			sysv_q <= '0;
		end else if (restart) begin
			gnu_q  <= esh_pkg::GNU_SEED;
			sysv_q <= '0;
		end else if (step) begin
			gnu_q  <= gnu_next;
			sysv_q <= sysv_next;
		end
	end

	assign gnu_run  = gnu_q;
	assign sysv_run = sysv_q;

endmodule
`default_nettype wire

@@ rtl/esh_mod_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esh_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns only the remainder.
// ----------------------------------------------------------------------------
module esh_mod_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire esh_pkg::mod_req_t req,
	output esh_pkg::mod_rsp_t      rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [esh_pkg::STEP_W-1:0]         cnt_q;
	logic [esh_pkg::GNU_W-1:0]          num_q;
	logic [esh_pkg::COUNT_W-1:0]        den_q;
	logic [esh_pkg::BUCKET_W-1:0]       rem_q;
	logic [esh_pkg::COUNT_W-1:0]        trial;
	logic                               fits;
	logic [esh_pkg::BUCKET_W-1:0]       rem_next;

	always_comb begin
		trial    = {rem_q, num_q[esh_pkg::GNU_W-1]};
		fits     = (trial >= den_q);
		rem_next = fits ? esh_pkg::BUCKET_W'(trial - den_q) : trial[esh_pkg::BUCKET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + esh_pkg::STEP_W'(1);
				if (cnt_q == esh_pkg::STEP_W'(esh_pkg::GNU_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[esh_pkg::GNU_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

@@ rtl/elf_symbol_hash_front_end_unit.sv @@
`default_nettype none
// Name bytes other than zero are taken one per cycle while in_stall is low.
// A zero byte ends the name; its result comes from two passes of the shared
// remainder unit, GNU hash first and then SysV, and loads once output is free.
// in_stall stays high from that zero byte until the result is loaded.
// Reset (arst_n low) restarts both hashes, drops any pending result and sets
// the bucket counts to one and the bloom settings to zero.
// ----------------------------------------------------------------------------
// elf_symbol_hash_front_end_unit: GNU and System V symbol hash front end
// Hashes a name byte stream and on its end gives both hashes, both bucket
// indexes, the bloom word index and the 64-bit bloom mask with up to two bits set.
// ----------------------------------------------------------------------------
module elf_symbol_hash_front_end_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [esh_pkg::NAME_W-1:0]        name_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [esh_pkg::GNU_W-1:0]         gnu_value,
	output logic      [esh_pkg::SYSV_W-1:0]        sysv_value,
	output logic      [esh_pkg::BUCKET_W-1:0]      gnu_bucket,
	output logic      [esh_pkg::BUCKET_W-1:0]      sysv_bucket,
	output logic      [esh_pkg::BLOOM_W-1:0]       bloom_word,
	output logic      [esh_pkg::MASK_W-1:0]        bloom_mask,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [esh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [esh_pkg::COUNT_W-1:0]       cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_G,
		ST_DIV_S,
		ST_LOAD
	} state_t;

	state_t state_q;

	logic [esh_pkg::COUNT_W-1:0]      gnu_count_q;
	logic [esh_pkg::COUNT_W-1:0]      sysv_count_q;
	logic [esh_pkg::BLOOM_LOG2_W-1:0] bloom_log2_q;
	logic [esh_pkg::SHIFT_W-1:0]      bloom_shift_q;

	logic [esh_pkg::GNU_W-1:0]        gnu_hold_q;
	logic [esh_pkg::SYSV_W-1:0]       sysv_hold_q;
	logic [esh_pkg::BUCKET_W-1:0]     gnu_bkt_q;
	logic [esh_pkg::BUCKET_W-1:0]     sysv_bkt_q;

	logic                             out_valid_q;
	logic [esh_pkg::GNU_W-1:0]        gnu_value_q;
	logic [esh_pkg::SYSV_W-1:0]       sysv_value_q;
	logic [esh_pkg::BUCKET_W-1:0]     gnu_bucket_q;
	logic [esh_pkg::BUCKET_W-1:0]     sysv_bucket_q;
	logic [esh_pkg::BLOOM_W-1:0]      bloom_word_q;
	logic [esh_pkg::MASK_W-1:0]       bloom_mask_q;

	logic                             in_take;
	logic                             end_of_name;
	logic                             out_free;
	logic [esh_pkg::GNU_W-1:0]        gnu_run;
	logic [esh_pkg::SYSV_W-1:0]       sysv_run;
	logic [esh_pkg::COUNT_W-1:0]      gnu_div;
	logic [esh_pkg::COUNT_W-1:0]      sysv_div;
	logic [esh_pkg::BLOOM_LOG2_W-1:0] bloom_lg;
	logic [esh_pkg::BLOOM_W:0]        word_mask;
	logic [esh_pkg::GNU_W-1:0]        shifted;
	logic [esh_pkg::BLOOM_W-1:0]      bloom_word_d;
	logic [esh_pkg::MASK_W-1:0]       bloom_mask_d;

	esh_pkg::mod_req_t                mod_req;
	esh_pkg::mod_rsp_t                mod_rsp;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign end_of_name = in_take && (name_byte == '0);
	assign out_free    = !out_valid_q || !out_stall;
	assign cfg_ready   = 1'b1;

	esh_hash_core u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (in_take && (name_byte != '0)),
		.restart  (end_of_name),
		.byte_in  (name_byte),
		.gnu_run  (gnu_run),
		.sysv_run (sysv_run)
	);

	esh_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gnu_count_q   <= esh_pkg::COUNT_W'(1);
			sysv_count_q  <= esh_pkg::COUNT_W'(1);
			bloom_log2_q  <= '0;
			bloom_shift_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				esh_pkg::REG_GNU_COUNT: begin
					gnu_count_q <= cfg_data;
				end
				esh_pkg::REG_SYSV_COUNT: begin
					sysv_count_q <= cfg_data;
				end
				esh_pkg::REG_BLOOM_LOG2: begin
					bloom_log2_q <= cfg_data[esh_pkg::BLOOM_LOG2_W-1:0];
				end
				esh_pkg::REG_BLOOM_SHIFT: begin
					bloom_shift_q <= cfg_data[esh_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		gnu_div  = esh_pkg::eff_count(gnu_count_q);
		sysv_div = esh_pkg::eff_count(sysv_count_q);
		bloom_lg = (bloom_log2_q > esh_pkg::BLOOM_LOG2_W'(esh_pkg::BLOOM_LOG2_MAX)) ?
			esh_pkg::BLOOM_LOG2_W'(esh_pkg::BLOOM_LOG2_MAX) : bloom_log2_q;
		word_mask    = ((esh_pkg::BLOOM_W+1)'(1) << bloom_lg) - (esh_pkg::BLOOM_W+1)'(1);
		bloom_word_d = gnu_hold_q[esh_pkg::BLOOM_LSB +: esh_pkg::BLOOM_W]
			& word_mask[esh_pkg::BLOOM_W-1:0];
		shifted      = gnu_hold_q >> bloom_shift_q;
		bloom_mask_d = (esh_pkg::MASK_W'(1) << gnu_hold_q[esh_pkg::MASK_IDX_W-1:0])
			| (esh_pkg::MASK_W'(1) << shifted[esh_pkg::MASK_IDX_W-1:0]);
	end

	// issue requests to the remainder unit: GNU hash first, then SysV
	always_comb begin
		mod_req.start    = 1'b0;
		mod_req.dividend = gnu_run;
		mod_req.divisor  = gnu_div;
		case (state_q)
			ST_IDLE: begin
				mod_req.start = end_of_name;
			end
			ST_DIV_G: begin
				mod_req.start    = mod_rsp.done;
				mod_req.dividend = esh_pkg::GNU_W'(sysv_hold_q);
				mod_req.divisor  = sysv_div;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gnu_hold_q    <= '0;
			sysv_hold_q   <= '0;
			gnu_bkt_q     <= '0;
			sysv_bkt_q    <= '0;
			out_valid_q   <= 1'b0;
			gnu_value_q   <= '0;
			sysv_value_q  <= '0;
			gnu_bucket_q  <= '0;
			sysv_bucket_q <= '0;
			bloom_word_q  <= '0;
			bloom_mask_q  <= '0;
		end else begin
			// the load state refills the output register itself
			if (out_valid_q && !out_stall && state_q != ST_LOAD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (end_of_name) begin
						gnu_hold_q  <= gnu_run;
						sysv_hold_q <= sysv_run;
						state_q     <= ST_DIV_G;
					end
				end
				ST_DIV_G: begin
					if (mod_rsp.done) begin
						gnu_bkt_q <= mod_rsp.rem;
						state_q   <= ST_DIV_S;
					end
				end
				ST_DIV_S: begin
					if (mod_rsp.done) begin
						sysv_bkt_q <= mod_rsp.rem;
						state_q    <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q   <= 1'b1;
						gnu_value_q   <= gnu_hold_q;
						sysv_value_q  <= sysv_hold_q;
						gnu_bucket_q  <= gnu_bkt_q;
						sysv_bucket_q <= sysv_bkt_q;
						bloom_word_q  <= bloom_word_d;
						bloom_mask_q  <= bloom_mask_d;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign gnu_value   = gnu_value_q;
	assign sysv_value  = sysv_value_q;
	assign gnu_bucket  = gnu_bucket_q;
	assign sysv_bucket = sysv_bucket_q;
	assign bloom_word  = bloom_word_q;
	assign bloom_mask  = bloom_mask_q;

`ifndef SYNTH
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> (state_q == ST_DIV_G || state_q == ST_DIV_S))
		else $error("remainder unit finished outside a division state");

	a_gnu_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_rsp.done && state_q == ST_DIV_G) |->
			(esh_pkg::COUNT_W'(mod_rsp.rem) < gnu_div))
		else $error("GNU bucket not below bucket count");

	a_sysv_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_rsp.done && state_q == ST_DIV_S) |->
			(esh_pkg::COUNT_W'(mod_rsp.rem) < sysv_div))
		else $error("SysV bucket not below bucket count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && out_valid_q && out_stall) |=>
			(state_q == ST_LOAD && out_valid_q && $stable(gnu_value_q)))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
